// ===== hdl/dsrgs_pkg.sv =====
package dsrgs_pkg;

   localparam int ANGLE_W     = 8;
   localparam int PULSE_W     = 12;
   localparam int KIND_W      = 4;
   localparam int DELAY_W     = 8;
   localparam int PC_W        = 4;
   localparam int SEG_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int NUM_W       = 20;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 28;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [ANGLE_W-1:0] ANGLE_FULL = 8'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_HOME = 8'd90;
   // floor(2^28 / 180)
   localparam logic [RECIP_W-1:0] RECIP_180  = 21'd1491308;

   localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2500;

   localparam logic AXIS_H = 1'b0;
   localparam logic AXIS_V = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK     = 4'd0,
      KIND_SET_H    = 4'd1,
      KIND_SET_V    = 4'd2,
      KIND_SET_BOTH = 4'd3,
      KIND_RAMP_H   = 4'd4,
      KIND_RAMP_V   = 4'd5,
      KIND_WAG      = 4'd6,
      KIND_SLOW_WAG = 4'd7,
      KIND_DROOP    = 4'd8,
      KIND_PERK     = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      PROG_RAMP     = 3'd0,
      PROG_WAG      = 3'd1,
      PROG_SLOW_WAG = 3'd2,
      PROG_DROOP    = 3'd3,
      PROG_PERK     = 3'd4
   } prog_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_MIN = 1'd0,
      CSR_PULSE_MAX = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic               valid;
      logic               axis;
      logic [ANGLE_W-1:0] target;
      logic [DELAY_W-1:0] delay;
   } seg_type;

   typedef enum logic [2:0] {
      OP_DECODE,
      OP_ADVANCE,
      OP_PMUL,
      OP_PRECIP,
      OP_PFIX,
      OP_RESULT
   } op_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_IF_NOT_ADV,
      JC_IF_SKIP
   } jc_type;

   typedef struct packed {
      op_type          op;
      logic            axis;
      jc_type          jc;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic mul;
      logic recip;
   } pulse_ctl_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] h_angle;
      logic [ANGLE_W-1:0] v_angle;
      logic [PULSE_W-1:0] h_pulse_us;
      logic [PULSE_W-1:0] v_pulse_us;
      logic               busy_res;
      logic               status;
      logic               moved;
   } rsp_data_type;

   function automatic seg_type mk_seg(logic axis, logic [ANGLE_W-1:0] target,
                                      logic [DELAY_W-1:0] delay);
      seg_type s;
      s.valid  = 1'b1;
      s.axis   = axis;
      s.target = target;
      s.delay  = delay;
      return s;
   endfunction

   // gesture segment tables; ramp segment comes from registers
   function automatic seg_type seg_rom(prog_type prog, logic [SEG_W-1:0] idx);
      seg_type s;
      s = '0;
      unique case (prog)
         PROG_WAG: begin
            unique case (idx)
               4'd0:             s = mk_seg(AXIS_V, 8'd110, 8'd10);
               4'd1, 4'd3, 4'd5: s = mk_seg(AXIS_H, 8'd55, 8'd8);
               4'd2, 4'd4, 4'd6: s = mk_seg(AXIS_H, 8'd125, 8'd8);
               4'd7:             s = mk_seg(AXIS_H, ANGLE_HOME, 8'd10);
               4'd8:             s = mk_seg(AXIS_V, ANGLE_HOME, 8'd10);
               default:          s = '0;
            endcase
         end
         PROG_SLOW_WAG: begin
            unique case (idx)
               4'd0, 4'd2: s = mk_seg(AXIS_H, 8'd65, 8'd18);
               4'd1, 4'd3: s = mk_seg(AXIS_H, 8'd115, 8'd18);
               4'd4:       s = mk_seg(AXIS_H, ANGLE_HOME, 8'd20);
               default:    s = '0;
            endcase
         end
         PROG_DROOP: begin
            unique case (idx)
               4'd0:    s = mk_seg(AXIS_H, ANGLE_HOME, 8'd15);
               4'd1:    s = mk_seg(AXIS_V, 8'd20, 8'd20);
               default: s = '0;
            endcase
         end
         PROG_PERK: begin
            unique case (idx)
               4'd0:    s = mk_seg(AXIS_H, ANGLE_HOME, 8'd10);
               4'd1:    s = mk_seg(AXIS_V, 8'd160, 8'd10);
               default: s = '0;
            endcase
         end
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic uword_type mk_uword(op_type op, logic axis, jc_type jc,
                                          logic [PC_W-1:0] target);
      uword_type w;
      w.op     = op;
      w.axis   = axis;
      w.jc     = jc;
      w.target = target;
      return w;
   endfunction

   // control store
   function automatic uword_type ucode_rom(logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         4'd0:    w = mk_uword(OP_DECODE,  AXIS_H, JC_IF_NOT_ADV, 4'd2);
         4'd1:    w = mk_uword(OP_ADVANCE, AXIS_H, JC_IF_SKIP,    4'd1);
         4'd2:    w = mk_uword(OP_PMUL,    AXIS_H, JC_NEXT,       4'd0);
         4'd3:    w = mk_uword(OP_PRECIP,  AXIS_H, JC_NEXT,       4'd0);
         4'd4:    w = mk_uword(OP_PFIX,    AXIS_H, JC_NEXT,       4'd0);
         4'd5:    w = mk_uword(OP_PMUL,    AXIS_V, JC_NEXT,       4'd0);
         4'd6:    w = mk_uword(OP_PRECIP,  AXIS_V, JC_NEXT,       4'd0);
         4'd7:    w = mk_uword(OP_PFIX,    AXIS_V, JC_NEXT,       4'd0);
         default: w = mk_uword(OP_RESULT,  AXIS_H, JC_NEXT,       4'd0);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/dsrgs_if.sv =====
interface dsrgs_req_if;
   logic                          valid;
   logic                          ready;
   logic [dsrgs_pkg::KIND_W-1:0]  kind;
   logic [dsrgs_pkg::ANGLE_W-1:0] angle;
   logic [dsrgs_pkg::DELAY_W-1:0] step_delay;

   modport source (output valid, kind, angle, step_delay, input ready);
   modport sink   (input valid, kind, angle, step_delay, output ready);
endinterface

interface dsrgs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dsrgs_pkg::ANGLE_W-1:0] h_angle;
   logic [dsrgs_pkg::ANGLE_W-1:0] v_angle;
   logic [dsrgs_pkg::PULSE_W-1:0] h_pulse_us;
   logic [dsrgs_pkg::PULSE_W-1:0] v_pulse_us;
   logic                          busy_res;
   logic                          status;
   logic                          moved;

   modport source (output valid, h_angle, v_angle, h_pulse_us, v_pulse_us,
                   busy_res, status, moved, input ready);
   modport sink   (input valid, h_angle, v_angle, h_pulse_us, v_pulse_us,
                   busy_res, status, moved, output ready);
endinterface

interface dsrgs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dsrgs_pkg::CSR_IDX_W-1:0] index;
   logic [dsrgs_pkg::PULSE_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/dual_servo_ramp_gesture_sequencer.sv =====
// Two-axis servo positioner with slew-limited ramps and built-in gestures.
// req channel: one item per command (kind, angle, step_delay); a tick item
// (kind 0) is expected once per millisecond and advances a running ramp or
// gesture. rsp channel: exactly one result item per request item, carrying
// both angles, both pulse widths, busy, reject status and a moved flag.
// csr channel: always ready; index 0 writes pulse_min_us, index 1 writes
// pulse_max_us. Write it only while no item is in flight.
// Sequencing: a microcoded sequencer runs each item through its control store:
// a decode step, then, for an item that advances a ramp or gesture, an advance
// step that repeats for each finished segment skipped, then the pulse steps
// for each axis, then the result step. The pulse divide uses one shared
// multiply-by-reciprocal unit, three steps per axis. One item at a time.
// req ready is high whenever no item is in the sequencer; a finished result
// sits in the output register, so the next item is taken while it waits.
// When rsp is stalled, the sequencer holds at its last step until the output
// register frees. Reset: angles 90, idle, pulse range 500..2500 us.
module dual_servo_ramp_gesture_sequencer (
   input  logic        clock,
   input  logic        reset,
   dsrgs_req_if.sink   req_chan,
   dsrgs_rsp_if.source rsp_chan,
   dsrgs_csr_if.sink   csr_chan
);

   logic                          active_ff, active_in;
   logic [dsrgs_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [dsrgs_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [dsrgs_pkg::ANGLE_W-1:0] ang_ff, ang_in;
   logic [dsrgs_pkg::DELAY_W-1:0] dly_ff, dly_in;
   logic [dsrgs_pkg::ANGLE_W-1:0] old_h_ff, old_h_in;
   logic [dsrgs_pkg::ANGLE_W-1:0] old_v_ff, old_v_in;
   logic                          status_ff, status_in;
   logic [dsrgs_pkg::ANGLE_W-1:0] h_ff, h_in;
   logic [dsrgs_pkg::ANGLE_W-1:0] v_ff, v_in;
   logic                          running_ff, running_in;
   dsrgs_pkg::prog_type           prog_ff, prog_in;
   logic [dsrgs_pkg::SEG_W-1:0]   seg_ff, seg_in;
   logic [dsrgs_pkg::DELAY_W-1:0] wait_ff, wait_in;
   logic                          raxis_ff, raxis_in;
   logic [dsrgs_pkg::ANGLE_W-1:0] rtarget_ff, rtarget_in;
   logic [dsrgs_pkg::DELAY_W-1:0] rdelay_ff, rdelay_in;
   logic [dsrgs_pkg::PULSE_W-1:0] pmin_ff, pmin_in;
   logic [dsrgs_pkg::PULSE_W-1:0] pmax_ff, pmax_in;
   logic [dsrgs_pkg::PULSE_W-1:0] hp_ff, hp_in;
   logic [dsrgs_pkg::PULSE_W-1:0] vp_ff, vp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dsrgs_pkg::rsp_data_type       rsp_ff, rsp_in;

   dsrgs_pkg::uword_type          uw;
   dsrgs_pkg::seg_type            seg;
   dsrgs_pkg::pulse_ctl_type      pulse_ctl;
   logic [dsrgs_pkg::ANGLE_W-1:0] cur_ang;
   logic [dsrgs_pkg::ANGLE_W-1:0] step_ang;
   logic [dsrgs_pkg::ANGLE_W-1:0] pulse_ang;
   logic [dsrgs_pkg::PULSE_W-1:0] pulse;
   logic                          at_target;
   logic                          seg_skip;
   logic                          need_adv;
   logic                          is_start;
   logic                          req_acc;
   logic                          out_free;

   assign uw      = dsrgs_pkg::ucode_rom(pc_ff);
   assign req_acc = req_chan.valid && !active_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = !active_ff;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.h_angle    = rsp_ff.h_angle;
   assign rsp_chan.v_angle    = rsp_ff.v_angle;
   assign rsp_chan.h_pulse_us = rsp_ff.h_pulse_us;
   assign rsp_chan.v_pulse_us = rsp_ff.v_pulse_us;
   assign rsp_chan.busy_res   = rsp_ff.busy_res;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.moved      = rsp_ff.moved;

   // segment fetch
   always_comb begin
      if (prog_ff == dsrgs_pkg::PROG_RAMP) begin
         seg.valid  = (seg_ff == '0);
         seg.axis   = raxis_ff;
         seg.target = rtarget_ff;
         seg.delay  = rdelay_ff;
      end else begin
         seg = dsrgs_pkg::seg_rom(prog_ff, seg_ff);
      end
      cur_ang   = (seg.axis == dsrgs_pkg::AXIS_V) ? v_ff : h_ff;
      at_target = (cur_ang == seg.target);
      seg_skip  = seg.valid && at_target;
      step_ang  = (cur_ang < seg.target) ? cur_ang + 1'b1 : cur_ang - 1'b1;
      is_start  = (kind_ff >= dsrgs_pkg::KIND_RAMP_H) && (kind_ff <= dsrgs_pkg::KIND_PERK);
      need_adv  = ((kind_ff == dsrgs_pkg::KIND_TICK) && running_ff && (wait_ff <= 8'd1))
               || (is_start && !running_ff);
   end

   assign pulse_ctl.mul   = active_ff && (uw.op == dsrgs_pkg::OP_PMUL);
   assign pulse_ctl.recip = active_ff && (uw.op == dsrgs_pkg::OP_PRECIP);
   assign pulse_ang       = (uw.axis == dsrgs_pkg::AXIS_V) ? v_ff : h_ff;

   dsrgs_pulse u_pulse (
      .clock     (clock),
      .ctl       (pulse_ctl),
      .angle     (pulse_ang),
      .pulse_min (pmin_ff),
      .pulse_max (pmax_ff),
      .pulse     (pulse)
   );

   always_comb begin
      active_in    = active_ff;
      pc_in        = pc_ff;
      kind_in      = kind_ff;
      ang_in       = ang_ff;
      dly_in       = dly_ff;
      old_h_in     = old_h_ff;
      old_v_in     = old_v_ff;
      status_in    = status_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      running_in   = running_ff;
      prog_in      = prog_ff;
      seg_in       = seg_ff;
      wait_in      = wait_ff;
      raxis_in     = raxis_ff;
      rtarget_in   = rtarget_ff;
      rdelay_in    = rdelay_ff;
      pmin_in      = pmin_ff;
      pmax_in      = pmax_ff;
      hp_in        = hp_ff;
      vp_in        = vp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_chan.valid) begin
         unique case (dsrgs_pkg::csr_idx_type'(csr_chan.index))
            dsrgs_pkg::CSR_PULSE_MIN: pmin_in = csr_chan.data;
            dsrgs_pkg::CSR_PULSE_MAX: pmax_in = csr_chan.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_acc) begin
         active_in = 1'b1;
         pc_in     = '0;
         kind_in   = req_chan.kind;
         ang_in    = (req_chan.angle > dsrgs_pkg::ANGLE_FULL) ? dsrgs_pkg::ANGLE_FULL
                                                               : req_chan.angle;
         dly_in    = req_chan.step_delay;
         old_h_in  = h_ff;
         old_v_in  = v_ff;
         status_in = 1'b0;
      end

      if (active_ff) begin
         unique case (uw.jc)
            dsrgs_pkg::JC_IF_NOT_ADV: pc_in = need_adv ? pc_ff + 1'b1 : uw.target;
            dsrgs_pkg::JC_IF_SKIP:    pc_in = seg_skip ? uw.target : pc_ff + 1'b1;
            default:                  pc_in = pc_ff + 1'b1;
         endcase

         unique case (uw.op)
            dsrgs_pkg::OP_DECODE: begin
               if (kind_ff == dsrgs_pkg::KIND_TICK) begin
                  if (running_ff && (wait_ff > 8'd1)) begin
                     wait_in = wait_ff - 1'b1;
                  end
               end else if (kind_ff <= dsrgs_pkg::KIND_PERK) begin
                  if (running_ff) begin
                     status_in = 1'b1;
                  end else begin
                     unique case (kind_ff)
                        dsrgs_pkg::KIND_SET_H: h_in = ang_ff;
                        dsrgs_pkg::KIND_SET_V: v_in = ang_ff;
                        dsrgs_pkg::KIND_SET_BOTH: begin
                           h_in = ang_ff;
                           v_in = ang_ff;
                        end
                        dsrgs_pkg::KIND_RAMP_H, dsrgs_pkg::KIND_RAMP_V: begin
                           raxis_in   = (kind_ff == dsrgs_pkg::KIND_RAMP_V);
                           rtarget_in = ang_ff;
                           rdelay_in  = (dly_ff == '0) ? 8'd1 : dly_ff;
                           prog_in    = dsrgs_pkg::PROG_RAMP;
                           seg_in     = '0;
                           running_in = 1'b1;
                        end
                        default: begin
                           prog_in    = dsrgs_pkg::prog_type'(3'(kind_ff - 4'd5));
                           seg_in     = '0;
                           running_in = 1'b1;
                        end
                     endcase
                  end
               end
            end
            dsrgs_pkg::OP_ADVANCE: begin
               if (!seg.valid) begin
                  running_in = 1'b0;
                  wait_in    = '0;
               end else if (at_target) begin
                  seg_in = seg_ff + 1'b1;
               end else begin
                  if (seg.axis == dsrgs_pkg::AXIS_V) begin
                     v_in = step_ang;
                  end else begin
                     h_in = step_ang;
                  end
                  wait_in = (seg.delay == '0) ? 8'd1 : seg.delay;
               end
            end
            dsrgs_pkg::OP_PFIX: begin
               if (uw.axis == dsrgs_pkg::AXIS_V) begin
                  vp_in = pulse;
               end else begin
                  hp_in = pulse;
               end
            end
            dsrgs_pkg::OP_RESULT: begin
               if (out_free) begin
                  rsp_in.h_angle    = h_ff;
                  rsp_in.v_angle    = v_ff;
                  rsp_in.h_pulse_us = hp_ff;
                  rsp_in.v_pulse_us = vp_ff;
                  rsp_in.busy_res   = running_ff;
                  rsp_in.status     = status_ff;
                  rsp_in.moved      = (h_ff != old_h_ff) || (v_ff != old_v_ff);
                  rsp_valid_in      = 1'b1;
                  active_in         = 1'b0;
                  pc_in             = '0;
               end else begin
                  pc_in = pc_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pc_ff        <= '0;
         h_ff         <= dsrgs_pkg::ANGLE_HOME;
         v_ff         <= dsrgs_pkg::ANGLE_HOME;
         running_ff   <= 1'b0;
         prog_ff      <= dsrgs_pkg::PROG_RAMP;
         seg_ff       <= '0;
         wait_ff      <= '0;
         raxis_ff     <= 1'b0;
         rtarget_ff   <= '0;
         rdelay_ff    <= '0;
         pmin_ff      <= dsrgs_pkg::PULSE_MIN_RST;
         pmax_ff      <= dsrgs_pkg::PULSE_MAX_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pc_ff        <= pc_in;
         h_ff         <= h_in;
         v_ff         <= v_in;
         running_ff   <= running_in;
         prog_ff      <= prog_in;
         seg_ff       <= seg_in;
         wait_ff      <= wait_in;
         raxis_ff     <= raxis_in;
         rtarget_ff   <= rtarget_in;
         rdelay_ff    <= rdelay_in;
         pmin_ff      <= pmin_in;
         pmax_ff      <= pmax_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      ang_ff    <= ang_in;
      dly_ff    <= dly_in;
      old_h_ff  <= old_h_in;
      old_v_ff  <= old_v_in;
      status_ff <= status_in;
      hp_ff     <= hp_in;
      vp_ff     <= vp_in;
      rsp_ff    <= rsp_in;
   end

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (h_ff <= dsrgs_pkg::ANGLE_FULL) && (v_ff <= dsrgs_pkg::ANGLE_FULL))
      else $error("servo angle out of range");

   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (wait_ff == '0))
      else $error("wait count left over while not running");

   a_prog_valid: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (prog_ff <= dsrgs_pkg::PROG_PERK))
      else $error("running with unknown program");

   a_idle_pc: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (pc_ff == '0))
      else $error("step counter not parked while idle");

endmodule

// ===== hdl/dsrgs_pulse.sv =====
module dsrgs_pulse (
   input  logic                          clock,
   input  dsrgs_pkg::pulse_ctl_type      ctl,
   input  logic [dsrgs_pkg::ANGLE_W-1:0] angle,
   input  logic [dsrgs_pkg::PULSE_W-1:0] pulse_min,
   input  logic [dsrgs_pkg::PULSE_W-1:0] pulse_max,
   output logic [dsrgs_pkg::PULSE_W-1:0] pulse
);

   logic [dsrgs_pkg::ANGLE_W-1:0] angle_rest;
   logic [dsrgs_pkg::NUM_W-1:0]   num_in;
   logic [dsrgs_pkg::NUM_W-1:0]   num_ff;
   logic [dsrgs_pkg::PROD_W-1:0]  prod_in;
   logic [dsrgs_pkg::PROD_W-1:0]  prod_ff;
   logic [dsrgs_pkg::QUOT_W-1:0]  quot_est;
   logic [dsrgs_pkg::NUM_W-1:0]   quot_x180;
   logic [dsrgs_pkg::NUM_W-1:0]   rem;

   always_comb begin
      angle_rest = dsrgs_pkg::ANGLE_FULL - angle;
      num_in = dsrgs_pkg::NUM_W'(pulse_min) * dsrgs_pkg::NUM_W'(angle_rest)
             + dsrgs_pkg::NUM_W'(pulse_max) * dsrgs_pkg::NUM_W'(angle);
      prod_in = dsrgs_pkg::PROD_W'(num_ff) * dsrgs_pkg::PROD_W'(dsrgs_pkg::RECIP_180);
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         num_ff <= num_in;
      end
      if (ctl.recip) begin
         prod_ff <= prod_in;
      end
   end

   // reciprocal estimate is exact or one low
   always_comb begin
      quot_est  = prod_ff[dsrgs_pkg::PROD_W-1:dsrgs_pkg::RECIP_SHIFT];
      quot_x180 = dsrgs_pkg::NUM_W'(quot_est) * dsrgs_pkg::NUM_W'(dsrgs_pkg::ANGLE_FULL);
      rem       = num_ff - quot_x180;
      if (rem >= dsrgs_pkg::NUM_W'(dsrgs_pkg::ANGLE_FULL)) begin
         pulse = dsrgs_pkg::PULSE_W'(quot_est + 1'b1);
      end else begin
         pulse = dsrgs_pkg::PULSE_W'(quot_est);
      end
   end

endmodule
